FILE: hdl/bldo_pkg.sv
// Shared types and constants for the bounded drop-oldest LIFO.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package bldo_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned DEPTH_W = 5;
  localparam int unsigned COUNT_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_READ_ALL = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  // Per-item fields carried alongside data coming back from the store
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [COUNT_W-1:0] count;
  } meta_t;

endpackage

FILE: hdl/bldo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read data holds while no read is issued.
`timescale 1ns / 1ps

module bldo_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/bounded_lifo_drop_oldest.sv
// Bounded LIFO with drop-oldest overwrite, entries kept in a circular RAM.
// Depends on bldo_pkg and bldo_ram.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word per operation:
//   op_i selects push, pop, peek, read-all or clear; entry_in_i is the push
//   payload, read_limit_i bounds read-all. Output channel (out_valid_o /
//   out_stall_i) returns result words; last_o marks the final one per item.
//   cfg_we_i writes capacity (0 acts as 1, above DEPTH acts as DEPTH) and
//   must only be written while the block is idle; nothing checks this.
//   Push, clear, failed pop/peek, empty read-all, unknown ops: the result
//   is registered at accept and shows in the next cycle; one item per
//   cycle while drained. Pop, peek and read-all: each RAM read goes to the
//   RAM read data register, then the output register; no op is taken
//   until the read stage is empty. Read-all gives one entry per cycle while
//   the output is not stalled; the single RAM read port sets that rate.
//   Input stalls while reads are in flight or the output is full and stalled.
//   Reset empties the stack, clears the operation counter and sets capacity
//   to 16; RAM contents are not cleared and are only read once written.
//   A stalled output holds its word; the RAM read data register acts as a
//   second stage, so read-all resumes without a bubble.

module bounded_lifo_drop_oldest
  import bldo_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ENTRY_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [ENTRY_BITS-1:0] entry_in_i,
  input  logic [LIMIT_W-1:0]    read_limit_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  ok_o,
  output logic [ENTRY_BITS-1:0] entry_out_o,
  output logic [DEPTH_W-1:0]    depth_now_o,
  output logic [COUNT_W-1:0]    op_count_o,
  output logic                  last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    slot_inc = (s == LAST_SLOT) ? '0 : AW'(s + 1'b1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    slot_dec = (s == '0) ? LAST_SLOT : AW'(s - 1'b1);
  endfunction

  // Architectural state
  logic [CAP_W-1:0]   cap_q;
  logic [AW-1:0]      top_q, top_d;
  logic [CW-1:0]      held_q, held_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;

  // Store read stream
  logic [CW-1:0]      rem_q, rem_d;
  logic [AW-1:0]      rd_slot_q, rd_slot_d;
  logic               rd_vld_q, rd_vld_d;
  logic               rd_last_q, rd_last_d;
  meta_t              meta_q, meta_d;

  // Output register
  logic                  out_vld_q, out_vld_d;
  logic                  out_ok_q, out_ok_d;
  logic [ENTRY_BITS-1:0] out_entry_q, out_entry_d;
  logic [DEPTH_W-1:0]    out_depth_q, out_depth_d;
  logic [COUNT_W-1:0]    out_cnt_q, out_cnt_d;
  logic                  out_last_q, out_last_d;

  logic                  busy, acc, issue_first, stream_issue, rd_consume, direct;
  logic                  is_read_all;
  logic [MW-1:0]         cap_eff, held_ext, limit_ext, n_ext;
  logic [CW-1:0]         n;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [ENTRY_BITS-1:0] ram_rdata;

  assign busy       = (rem_q != '0) || rd_vld_q;
  assign in_stall_o = busy || (out_vld_q && out_stall_i);
  assign acc        = in_valid_i && !in_stall_o;
  assign rd_consume = rd_vld_q && (!out_vld_q || !out_stall_i);
  assign stream_issue = (rem_q != '0) && (!rd_vld_q || rd_consume);

  assign cap_eff = (cap_q == '0) ? MW'(1) :
                   (MW'(cap_q) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(cap_q);
  assign held_ext  = MW'(held_q);
  assign limit_ext = MW'(read_limit_i);
  assign n_ext     = (limit_ext < held_ext) ? limit_ext : held_ext;
  assign n         = CW'(n_ext);
  assign is_read_all = (op_i == OP_READ_ALL);

  always_comb begin
    top_d       = top_q;
    held_d      = held_q;
    cnt_d       = cnt_q;
    ram_we      = 1'b0;
    issue_first = 1'b0;
    if (acc) begin
      unique case (op_e'(op_i))
        OP_PUSH: begin
          cnt_d  = cnt_q + 1'b1;
          top_d  = slot_inc(top_q);
          ram_we = 1'b1;
          held_d = (held_ext < cap_eff) ? CW'(held_q + 1'b1) : CW'(cap_eff);
        end
        OP_POP: begin
          if (held_q != '0) begin
            issue_first = 1'b1;
            cnt_d       = cnt_q + 1'b1;
            top_d       = slot_dec(top_q);
            held_d      = CW'(held_q - 1'b1);
          end
        end
        OP_PEEK: begin
          issue_first = (held_q != '0);
        end
        OP_READ_ALL: begin
          issue_first = (n != '0);
        end
        OP_CLEAR: begin
          held_d = '0;
          top_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign direct    = acc && !issue_first;
  assign ram_re    = issue_first || stream_issue;
  assign ram_raddr = issue_first ? top_q : rd_slot_q;

  always_comb begin
    rem_d     = rem_q;
    rd_slot_d = rd_slot_q;
    rd_last_d = rd_last_q;
    meta_d    = meta_q;
    if (issue_first) begin
      rem_d        = is_read_all ? CW'(n - 1'b1) : '0;
      rd_slot_d    = slot_dec(top_q);
      rd_last_d    = is_read_all ? (n == CW'(1)) : 1'b1;
      meta_d.depth = DEPTH_W'(MW'(held_d));
      meta_d.count = cnt_d;
    end else if (stream_issue) begin
      rem_d     = CW'(rem_q - 1'b1);
      rd_slot_d = slot_dec(rd_slot_q);
      rd_last_d = (rem_q == CW'(1));
    end
    rd_vld_d = ram_re ? 1'b1 : (rd_consume ? 1'b0 : rd_vld_q);
  end

  // Result words: direct results at accept, store data when the stage drains
  always_comb begin
    out_ok_d    = out_ok_q;
    out_entry_d = out_entry_q;
    out_depth_d = out_depth_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    out_vld_d   = out_vld_q && out_stall_i;
    if (direct) begin
      out_vld_d   = 1'b1;
      out_ok_d    = (op_i == OP_PUSH) || (op_i == OP_CLEAR);
      out_entry_d = '0;
      out_depth_d = DEPTH_W'(MW'(held_d));
      out_cnt_d   = cnt_d;
      out_last_d  = 1'b1;
    end else if (rd_consume) begin
      out_vld_d   = 1'b1;
      out_ok_d    = 1'b1;
      out_entry_d = ram_rdata;
      out_depth_d = meta_q.depth;
      out_cnt_d   = meta_q.count;
      out_last_d  = rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_W'(16);
      top_q     <= '0;
      held_q    <= '0;
      cnt_q     <= '0;
      rem_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      top_q     <= top_d;
      held_q    <= held_d;
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q   <= rd_slot_d;
    rd_last_q   <= rd_last_d;
    meta_q      <= meta_d;
    out_ok_q    <= out_ok_d;
    out_entry_q <= out_entry_d;
    out_depth_q <= out_depth_d;
    out_cnt_q   <= out_cnt_d;
    out_last_q  <= out_last_d;
  end

  // Writes only happen at push accept; reads only at a pop, peek or read-all
  // accept or while the input stalls, so no cycle both writes and reads.
  bldo_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (top_d),
    .wdata_i (entry_in_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_vld_q;
  assign ok_o        = out_ok_q;
  assign entry_out_o = out_entry_q;
  assign depth_now_o = out_depth_q;
  assign op_count_o  = out_cnt_q;
  assign last_o      = out_last_q;

  a_no_accept_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> in_stall_o)
    else $error("input accepted while store data in flight");

  a_stream_fed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) |-> rd_vld_q)
    else $error("read-all stream lost its data stage");

  a_not_last_has_more : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && !rd_last_q) |-> (rem_q != '0))
    else $error("non-final read with nothing remaining");

  a_no_rw_same_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("store written and read in the same cycle");

endmodule
